>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define SSR_ASSERT(label, clk, rst, prop, msg)
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/ssr_pkg.sv
package ssr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPL_MAX_DEF    = 16;
  localparam int DATA_W          = 64;   // window snapshot, 8 bytes max
  localparam int REPL_W          = 128;  // replacement bytes 0..15
  localparam int CNT_W           = 5;    // results per command, 0..16
  localparam int IDX_W           = 4;    // beat index within a command
  localparam int DATA_IDX_W      = 3;    // byte index within the window snapshot
  localparam int CFG_INDEX_W     = 3;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES = 3'd0,
    REG_PATTERN_LEN   = 3'd1,
    REG_REPL_LOW      = 3'd2,
    REG_REPL_HIGH     = 3'd3,
    REG_REPL_LEN      = 3'd4
  } reg_index_t;

  // One command from the front to the back: emit count bytes, either from
  // the window snapshot (oldest first) or from the replacement string.
  // A zero count with last set is a bare end mark.
  typedef struct packed {
    logic              repl;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

>>> hdl/ssr_front.sv
`include "assert_macros.svh"

module ssr_front #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int REPL_MAX    = ssr_pkg::REPL_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    q_full,
  input  logic [7:0]              ch,
  input  logic                    end_of_text,
  input  logic [63:0]             pattern_bytes,
  input  logic [3:0]              pattern_len,
  input  logic [4:0]              repl_len,
  output logic                    cmd_push,
  output ssr_pkg::cmd_t           cmd
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][7:0] window;
  logic [PATTERN_MAX-1:0][7:0] window_next;
  logic [PATTERN_MAX-1:0][7:0] win_app;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_next;
  logic [FILL_W-1:0]           f;
  logic [FILL_W-1:0]           plen;
  logic [FILL_W-1:0]           n;
  logic [ssr_pkg::CNT_W-1:0]   rlen;
  logic                        accept;
  logic                        mismatch;
  logic                        is_match;

  assign accept = push && !q_full;

  always_comb begin
    plen = (pattern_len > 4'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX) : FILL_W'(pattern_len);
    rlen = (repl_len > 5'(REPL_MAX)) ? ssr_pkg::CNT_W'(REPL_MAX) : ssr_pkg::CNT_W'(repl_len);
    f    = fill + FILL_W'(1);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_app[i] = (fill == FILL_W'(i)) ? ch : window[i];
    end
    mismatch = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (FILL_W'(i) < plen && win_app[i] != pattern_bytes[8*i +: 8]) begin
        mismatch = 1'b1;
      end
    end
    is_match = 1'b0;
    if (plen == '0) begin
      n = f;
    end else if (f > plen) begin
      // pattern was shortened: drain until fewer than plen remain
      n = f - plen + FILL_W'(1);
    end else if (f == plen) begin
      is_match = !mismatch;
      n = mismatch ? FILL_W'(1) : '0;
    end else begin
      n = '0;
    end
    if (end_of_text && !is_match) begin
      n = f;
    end
  end

  always_comb begin
    window_next = win_app >> {n, 3'b000};
    fill_next   = (end_of_text || is_match) ? '0 : f - n;
    cmd.repl    = is_match;
    cmd.last    = end_of_text;
    cmd.count   = is_match ? rlen : ssr_pkg::CNT_W'(n);
    cmd.data    = ssr_pkg::DATA_W'(win_app);
    cmd_push    = accept && (end_of_text || (is_match ? (rlen != '0) : (n != '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  `SSR_ASSERT(a_fill_range, clk, rst, fill < FILL_W'(PATTERN_MAX), "window fill out of range")
  `SSR_ASSERT_NEXT(a_fill_clear, clk, rst, accept && end_of_text, fill == '0,
    "window not cleared at end of text")

endmodule

>>> hdl/ssr_cmd_queue.sv
`include "assert_macros.svh"

module ssr_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ssr_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output ssr_pkg::cmd_t rd_cmd,
  output logic          empty
);

  localparam int DEPTH = ssr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssr_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  `SSR_ASSERT(a_no_overflow, clk, rst, wr_en |-> !full, "command queue overflow")
  `SSR_ASSERT(a_no_underflow, clk, rst, rd_en |-> !empty, "command queue underflow")

endmodule

>>> hdl/ssr_back.sv
`include "assert_macros.svh"

module ssr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  ssr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic [63:0]   repl_low_bytes,
  input  logic [63:0]   repl_high_bytes,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          has_byte,
  output logic          end_of_output,
  output logic [15:0]   total_len
);

  logic [ssr_pkg::IDX_W-1:0]  idx;
  logic [15:0]                out_count;
  logic [15:0]                cnt_inc;
  logic [ssr_pkg::REPL_W-1:0] repl_vec;
  logic [7:0]                 byte_sel;
  logic                       ov;
  logic                       adv;
  logic                       take;
  logic                       is_bare;
  logic                       last_beat;

  assign empty = !ov;

  always_comb begin
    repl_vec  = {repl_high_bytes, repl_low_bytes};
    adv       = !ov || pop;
    take      = adv && !cmd_empty;
    is_bare   = (cmd.count == '0);
    last_beat = is_bare || ({1'b0, idx} == cmd.count - ssr_pkg::CNT_W'(1));
    cmd_pop   = take && last_beat;
    byte_sel  = cmd.repl ? repl_vec[{idx, 3'b000} +: 8]
                         : cmd.data[{idx[ssr_pkg::DATA_IDX_W-1:0], 3'b000} +: 8];
    cnt_inc   = (out_count == 16'hFFFF) ? out_count : out_count + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov        <= 1'b0;
      idx       <= '0;
      out_count <= '0;
    end else if (take) begin
      ov  <= 1'b1;
      idx <= last_beat ? '0 : idx + ssr_pkg::IDX_W'(1);
      if (cmd.last && last_beat) begin
        out_count <= '0;
      end else if (!is_bare) begin
        out_count <= cnt_inc;
      end
    end else if (adv) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte      <= is_bare ? 8'd0 : byte_sel;
      has_byte      <= !is_bare;
      end_of_output <= cmd.last && last_beat;
      total_len     <= is_bare ? out_count : cnt_inc;
    end
  end

  `SSR_ASSERT(a_bare_is_end, clk, rst, ov && !has_byte |-> end_of_output,
    "bare result without end mark")
  `SSR_ASSERT(a_bare_cmd_last, clk, rst, !cmd_empty && cmd.count == '0 |-> cmd.last,
    "empty command without end of text")
  `SSR_ASSERT(a_count_cleared, clk, rst, ov && end_of_output |-> out_count == '0,
    "output count not cleared after end of string")

endmodule

>>> hdl/stream_string_replace_top.sv
// Streaming fixed-string search and replace.
// Input queue side: present ch and end_of_text with push; a transaction
// happens on a clock edge with push high and full low. One byte per cycle
// is taken as long as the internal command queue (4 entries) has room.
// Result queue side: while empty is low the oldest result sits on out_byte,
// has_byte, end_of_output and total_len; pop with empty low takes it.
// The back end delivers one result per cycle while the receiver pops, so
// an item that causes k results (k up to 16 on a replacement) holds the
// back end until all k are out; sustained input rate is one byte per cycle
// for plain copy traffic. The first result of an item passes the command
// queue and the output register and waits on the result ports for a pop.
// If the receiver stalls, results wait in the output register, then the
// command queue fills and full goes high; nothing is dropped.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle; this is not enforced.
// Synchronous reset (rst) clears config, window fill, queue and output valid.
module stream_string_replace_top #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int REPL_MAX    = ssr_pkg::REPL_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      ch,
  input  logic                            end_of_text,
  input  logic                            pop,
  output logic                            empty,
  output logic [7:0]                      out_byte,
  output logic                            has_byte,
  output logic                            end_of_output,
  output logic [15:0]                     total_len,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  logic [63:0]   pattern_bytes;
  logic [3:0]    pattern_len;
  logic [63:0]   repl_low_bytes;
  logic [63:0]   repl_high_bytes;
  logic [4:0]    repl_len;

  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_empty;
  ssr_pkg::cmd_t cmd_in;
  ssr_pkg::cmd_t cmd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes   <= '0;
      pattern_len     <= '0;
      repl_low_bytes  <= '0;
      repl_high_bytes <= '0;
      repl_len        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::REG_PATTERN_BYTES: pattern_bytes   <= cfg_data;
        ssr_pkg::REG_PATTERN_LEN:   pattern_len     <= cfg_data[3:0];
        ssr_pkg::REG_REPL_LOW:      repl_low_bytes  <= cfg_data;
        ssr_pkg::REG_REPL_HIGH:     repl_high_bytes <= cfg_data;
        ssr_pkg::REG_REPL_LEN:      repl_len        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  ssr_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPL_MAX    (REPL_MAX)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (full),
    .ch            (ch),
    .end_of_text   (end_of_text),
    .pattern_bytes (pattern_bytes),
    .pattern_len   (pattern_len),
    .repl_len      (repl_len),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  ssr_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_out),
    .empty  (cmd_empty)
  );

  ssr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd_out),
    .cmd_pop         (cmd_pop),
    .repl_low_bytes  (repl_low_bytes),
    .repl_high_bytes (repl_high_bytes),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .has_byte        (has_byte),
    .end_of_output   (end_of_output),
    .total_len       (total_len)
  );

endmodule

>>> tb/stream_string_replace_top_tb.sv
`timescale 1ns / 100ps

module stream_string_replace_top_tb;

  typedef struct packed {
    logic [7:0]  b;
    logic        has;
    logic        last;
    logic [15:0] total;
  } out_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          ch = 8'h01;
  logic                end_of_text = 1'b0;
  logic                pop = 1'b0;
  logic                empty;
  logic [7:0]          out_byte;
  logic                has_byte;
  logic                end_of_output;
  logic [15:0]         total_len;
  logic                cfg_we = 1'b0;
  ssr_pkg::reg_index_t cfg_index = ssr_pkg::REG_PATTERN_BYTES;
  logic [63:0]         cfg_data = 64'h0;

  // mirror of the block's registers and string state
  logic [63:0] pat_bytes = 64'h0;
  logic [3:0]  pat_len = 4'd0;
  logic [63:0] repl_lo = 64'h0;
  logic [63:0] repl_hi = 64'h0;
  logic [4:0]  repl_len = 5'd0;
  logic [7:0]  win [8];
  int          fill = 0;
  int          out_cnt = 0;

  out_item_t   replaced_q[$];
  out_item_t   step_out[$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;

  stream_string_replace_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .ch           (ch),
    .end_of_text  (end_of_text),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .end_of_output(end_of_output),
    .total_len    (total_len),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int eff_plen();
    return (pat_len > 4'd8) ? 8 : int'(pat_len);
  endfunction

  function automatic void put_out(input logic [7:0] b);
    out_item_t r;
    if (out_cnt < 65535) out_cnt++;
    r.b = b;
    r.has = 1'b1;
    r.last = 1'b0;
    r.total = out_cnt[15:0];
    step_out.push_back(r);
  endfunction

  function automatic void shift_oldest();
    put_out(win[0]);
    for (int i = 1; i < fill; i++) win[i-1] = win[i];
    fill--;
  endfunction

  function automatic void replace_step(input logic [7:0] c, input logic eot);
    int plen;
    int rlen;
    logic hit;
    out_item_t mark;
    plen = eff_plen();
    rlen = (repl_len > 5'd16) ? 16 : int'(repl_len);
    step_out.delete();
    if (fill > 7) fill = 7;
    win[fill] = c;
    fill++;
    if (plen == 0 || fill > plen) begin
      // also covers a pattern shortened while bytes were pending
      while (fill > 0 && fill >= plen) shift_oldest();
    end else if (fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++)
          put_out(i < 8 ? repl_lo[8*i +: 8] : repl_hi[8*(i-8) +: 8]);
        fill = 0;
      end else begin
        shift_oldest();
      end
    end
    if (eot) begin
      while (fill > 0) shift_oldest();
      if (step_out.size() == 0) begin
        // nothing left to emit: bare end mark, not counted
        mark.b = 8'h00;
        mark.has = 1'b0;
        mark.last = 1'b0;
        mark.total = out_cnt[15:0];
        step_out.push_back(mark);
      end
      mark = step_out.pop_back();
      mark.last = 1'b1;
      step_out.push_back(mark);
      fill = 0;
      out_cnt = 0;
    end
    foreach (step_out[i]) replaced_q.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------- drivers
  always @(negedge clk)
    pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk)
    if (hold_left > 0) hold_left <= hold_left - 1;

  task automatic send_char(input logic [7:0] c, input logic eot);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    ch <= c;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    replace_step(c, eot);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (replaced_q.size() != 0) @(posedge clk);
    // items that make no output may still be in the pipe
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input ssr_pkg::reg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ssr_pkg::REG_PATTERN_BYTES: pat_bytes = val;
      ssr_pkg::REG_PATTERN_LEN:   pat_len = val[3:0];
      ssr_pkg::REG_REPL_LOW:      repl_lo = val;
      ssr_pkg::REG_REPL_HIGH:     repl_hi = val;
      ssr_pkg::REG_REPL_LEN:      repl_len = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] pb, input logic [3:0] pl,
                            input logic [63:0] rlo, input logic [63:0] rhi,
                            input logic [4:0] rn);
    write_reg(ssr_pkg::REG_PATTERN_BYTES, pb);
    write_reg(ssr_pkg::REG_PATTERN_LEN, {60'h0, pl});
    write_reg(ssr_pkg::REG_REPL_LOW, rlo);
    write_reg(ssr_pkg::REG_REPL_HIGH, rhi);
    write_reg(ssr_pkg::REG_REPL_LEN, {59'h0, rn});
  endtask

  task automatic random_config();
    logic [63:0] pb;
    int pl;
    int rn;
    pl = $urandom_range(0, 9);
    if (pl == 9) pl = $urandom_range(9, 15);
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 8; i++) pb[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
    end else begin
      pb = {$urandom, $urandom};
    end
    rn = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    set_config(pb, pl[3:0], {$urandom, $urandom}, {$urandom, $urandom}, rn[4:0]);
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (replaced_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected transaction: byte %h has %b end %b total %0d",
                   $time, out_byte, has_byte, end_of_output, total_len);
      end else begin
        want = replaced_q.pop_front();
        if (out_byte !== want.b || has_byte !== want.has ||
            end_of_output !== want.last || total_len !== want.total) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: mismatch: exp byte %h has %b end %b total %0d, got %h %b %b %0d",
                     $time, want.b, want.has, want.last, want.total,
                     out_byte, has_byte, end_of_output, total_len);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // copy through after reset, bytes 01 and FF
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b1);
    drain();
    // "ab" -> "XYZ": miss, hit, leftover flushed at end
    set_config(64'h6261, 4'd2, 64'h5A5958, 64'h0, 5'd3);
    send_char(8'h63, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h61, 1'b1);
    drain();
    // empty replacement on the last byte gives a bare end mark
    write_reg(ssr_pkg::REG_REPL_LEN, 64'd0);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b1);
    drain();
    // oversized lengths clamp to 8 and 16
    set_config(64'h6867_6665_6463_6261, 4'd15, 64'hFF00_A55A_0102_80FF,
               64'h7F01_FE00_00FF_C33C, 5'd31);
    for (int i = 0; i < 8; i++) send_char(8'h61 + 8'(i), 1'b0);
    send_char(8'h7A, 1'b1);
    drain();
    // zero pattern byte never matches text
    write_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h0061);
    write_reg(ssr_pkg::REG_PATTERN_LEN, 64'd2);
    send_char(8'h61, 1'b0);
    send_char(8'h61, 1'b1);
    drain();
    // pattern shortened while five bytes are pending
    write_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h6867_6665_6463_6261);
    write_reg(ssr_pkg::REG_PATTERN_LEN, 64'd8);
    for (int i = 0; i < 5; i++) send_char(8'h70 + 8'(i), 1'b0);
    drain();
    write_reg(ssr_pkg::REG_PATTERN_LEN, 64'd2);
    send_char(8'h75, 1'b0);
    send_char(8'h76, 1'b1);
    drain();
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int pick;
    int plen;
    int cut;
    int part;
    logic [7:0] b;
    logic [7:0] txt[$];
    sent = 0;
    while (sent < n_items) begin
      random_config();
      plen = eff_plen();
      txt.delete();
      cut = $urandom_range(8, 40);
      while (txt.size() < cut) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 && plen > 0) begin
          for (int i = 0; i < plen; i++) begin
            b = pat_bytes[8*i +: 8];
            txt.push_back(b != 8'h00 ? b : 8'($urandom_range(1, 255)));
          end
        end else if (pick < 55 && plen > 1) begin
          // partial pattern broken by an arbitrary byte
          part = $urandom_range(1, plen - 1);
          for (int i = 0; i < part; i++) begin
            b = pat_bytes[8*i +: 8];
            txt.push_back(b != 8'h00 ? b : 8'($urandom_range(1, 255)));
          end
          txt.push_back(8'($urandom_range(1, 255)));
        end else if (pick < 85) begin
          txt.push_back(8'h61 + 8'($urandom_range(0, 2)));
        end else begin
          txt.push_back(8'($urandom_range(1, 255)));
        end
      end
      foreach (txt[i]) send_char(txt[i], $urandom_range(0, 99) < 6);
      sent += txt.size();
      drain();
    end
  endtask

  task automatic test_backpressure();
    int save;
    save = send_idle_pct;
    send_idle_pct = 0;
    set_config(64'h61, 4'd1, 64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd16);
    @(posedge clk);
    hold_left = 300;
    repeat (40) send_char($urandom_range(0, 1) ? 8'h61 : 8'($urandom_range(1, 255)), 1'b0);
    send_char(8'h61, 1'b1);
    drain();
    send_idle_pct = save;
  endtask

  task automatic test_long_string();
    // every z byte expands to 16, a long run of full replacement bursts
    set_config(64'h7A, 4'd1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd16);
    repeat (40) send_char(8'h7A, 1'b0);
    send_char(8'h41, 1'b1);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 86;
    test_directed();
    test_random(90);
    send_idle_pct = 86;
    recv_idle_pct = 36;
    test_backpressure();
    test_random(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(90);
    test_long_string();
    if (err_cnt == 0 && replaced_q.size() == 0)
      $display("stream_string_replace_top_tb: PASS");
    else
      $display("stream_string_replace_top_tb: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("stream_string_replace_top_tb: FAIL");
    $finish;
  end

endmodule
